>>> hw/rtl/huffman_code_builder_top_macros.svh
// Assertion macros used by the checker of the code builder.
`ifndef HUFFMAN_CODE_BUILDER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCB_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hcb_pkg.sv
// Shared constants, types and state codes of the Huffman code builder.
package hcb_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int WEIGHT_BITS = 24;
    localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_W      = $clog2(NODE_DEPTH);
    localparam int LEAF_AW     = $clog2(MAX_SYMBOLS);
    localparam int CNT_W       = LEAF_AW + 1;
    localparam int SUM_W       = WEIGHT_BITS + LEAF_AW;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 6;
    localparam int CODE_W      = 63;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 80;

    typedef logic [NODE_W-1:0] node_t;

    typedef struct packed {
        node_t left;
        node_t right;
    } node_pair_t;

    typedef struct packed {
        node_t             node;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } walk_entry_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_MERGE,
        ST_EVAL,
        ST_CHILD,
        ST_LEAF,
        ST_OUT,
        ST_POP
    } hcb_state_t;

endpackage

>>> hw/rtl/hcb_node_store.sv
// Node memories: weight of every node and the child pair of every joined node.
module hcb_node_store
    import hcb_pkg::*;
(
    input  logic             aclk,
    input  logic             wt_wr_en,
    input  node_t            wt_wr_addr,
    input  logic [SUM_W-1:0] wt_wr_data,
    input  node_t            wt_rd_addr,
    output logic [SUM_W-1:0] wt_rd_data,
    input  logic             ch_wr_en,
    input  node_t            ch_wr_addr,
    input  node_pair_t       ch_wr_data,
    input  node_t            ch_rd_addr,
    output node_pair_t       ch_rd_data
);

    logic [SUM_W-1:0] weight_mem [NODE_DEPTH];
    node_pair_t       child_mem  [NODE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wt_wr_en) begin
            weight_mem[wt_wr_addr] <= wt_wr_data;
        end
        wt_rd_data <= weight_mem[wt_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (ch_wr_en) begin
            child_mem[ch_wr_addr] <= ch_wr_data;
        end
        ch_rd_data <= child_mem[ch_rd_addr];
    end

endmodule

>>> hw/rtl/hcb_leaf_store.sv
// Symbol memory of the loaded leaves.
module hcb_leaf_store
    import hcb_pkg::*;
(
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [LEAF_AW-1:0] wr_addr,
    input  logic [SYM_W-1:0]   wr_data,
    input  logic [LEAF_AW-1:0] rd_addr,
    output logic [SYM_W-1:0]   rd_data
);

    logic [SYM_W-1:0] sym_mem [MAX_SYMBOLS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sym_mem[wr_addr] <= wr_data;
        end
        rd_data <= sym_mem[rd_addr];
    end

endmodule

>>> hw/rtl/hcb_walk_stack.sv
// Stack memory of pending right subtrees for the tree walk.
module hcb_walk_stack
    import hcb_pkg::*;
(
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [LEAF_AW-1:0] wr_addr,
    input  walk_entry_t        wr_data,
    input  logic [LEAF_AW-1:0] rd_addr,
    output walk_entry_t        rd_data
);

    walk_entry_t stack_mem [MAX_SYMBOLS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_data <= stack_mem[rd_addr];
    end

endmodule

>>> hw/rtl/huffman_code_builder_top.sv
// Huffman code builder: loads weighted symbols, builds the tree, streams codes.
// Symbols load at one beat per cycle; the beat with tlast starts the build and
// the input stays stalled until the last code beat has gone. Each of the n-1
// joins scans every node made so far once through the single read port of the
// weight memory (SCAN, SCAN_TAIL, then MERGE). The walk then handles each
// internal node in EVAL and CHILD and each leaf in EVAL, LEAF and OUT, then
// POP for all but the final leaf, with OUT waiting on m_tready. Ties go to the
// lower node index, which is the order in which nodes entered the queue.
module huffman_code_builder_top
    import hcb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // symbol[7:0], weight[31:8]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // code_symbol[7:0], code_length[13:8],
                                             // code_bits[76:14], zero[79:77]
    output logic                  m_tlast
);

    hcb_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    node_t             next_reg, next_next;
    logic [NODE_DEPTH-1:0] live_reg, live_next;
    node_t             scan_idx_reg, scan_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    node_t             rd_idx_reg, rd_idx_next;
    node_t             b1_reg, b1_next, b2_reg, b2_next;
    logic [SUM_W-1:0]  b1w_reg, b1w_next, b2w_reg, b2w_next;
    logic              b1v_reg, b1v_next, b2v_reg, b2v_next;
    walk_entry_t       cur_reg, cur_next;
    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic              out_vld_reg, out_vld_next;
    logic              out_last_reg, out_last_next;
    logic [SYM_W-1:0]  out_sym_reg, out_sym_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;

    logic              in_beat;
    logic              room;
    logic [CNT_W-1:0]  n_new;
    logic [CNT_W:0]    root_idx;
    logic [SUM_W-1:0]  wt_rd_data;
    node_pair_t        ch_rd_data;
    node_pair_t        ch_wr_data;
    logic [SYM_W-1:0]  sym_rd_data;
    walk_entry_t       stk_rd_data;
    walk_entry_t       push_entry;
    logic              wt_wr_en, ch_wr_en, stk_wr_en, sym_wr_en;
    node_t             wt_wr_addr;
    logic [SUM_W-1:0]  wt_wr_data;
    node_t             ch_rd_addr;
    logic [LEAF_AW-1:0] stk_rd_addr;

    assign s_tready = (state_reg == ST_LOAD);
    assign in_beat  = s_tvalid && s_tready;
    assign room     = (cnt_reg < CNT_W'(MAX_SYMBOLS));
    assign n_new    = room ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign root_idx = {n_reg, 1'b0} - (CNT_W+1)'(2);

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_code_reg, out_len_reg, out_sym_reg};

    assign sym_wr_en  = in_beat && room;
    assign wt_wr_en   = sym_wr_en || (state_reg == ST_MERGE);
    assign wt_wr_addr = (state_reg == ST_MERGE) ? next_reg : NODE_W'(cnt_reg);
    assign wt_wr_data = (state_reg == ST_MERGE) ? b1w_reg + b2w_reg
                                                : SUM_W'(s_tdata[31:8]);
    assign ch_wr_en   = (state_reg == ST_MERGE);
    assign ch_wr_data = '{left: b1_reg, right: b2_reg};
    assign ch_rd_addr = cur_reg.node;
    assign stk_wr_en  = (state_reg == ST_CHILD);
    assign stk_rd_addr = LEAF_AW'(sp_reg - CNT_W'(1));
    assign push_entry = '{node: ch_rd_data.right, len: cur_reg.len + LEN_W'(1),
                          code: {cur_reg.code[CODE_W-2:0], 1'b1}};

    hcb_node_store u_nodes (
        .aclk       (aclk),
        .wt_wr_en   (wt_wr_en),
        .wt_wr_addr (wt_wr_addr),
        .wt_wr_data (wt_wr_data),
        .wt_rd_addr (scan_idx_reg),
        .wt_rd_data (wt_rd_data),
        .ch_wr_en   (ch_wr_en),
        .ch_wr_addr (next_reg),
        .ch_wr_data (ch_wr_data),
        .ch_rd_addr (ch_rd_addr),
        .ch_rd_data (ch_rd_data)
    );

    hcb_leaf_store u_leaves (
        .aclk    (aclk),
        .wr_en   (sym_wr_en),
        .wr_addr (cnt_reg[LEAF_AW-1:0]),
        .wr_data (s_tdata[7:0]),
        .rd_addr (cur_reg.node[LEAF_AW-1:0]),
        .rd_data (sym_rd_data)
    );

    hcb_walk_stack u_stack (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (sp_reg[LEAF_AW-1:0]),
        .wr_data (push_entry),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        next_next     = next_reg;
        live_next     = live_reg;
        scan_idx_next = scan_idx_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        b1_next       = b1_reg;
        b1w_next      = b1w_reg;
        b1v_next      = b1v_reg;
        b2_next       = b2_reg;
        b2w_next      = b2w_reg;
        b2v_next      = b2v_reg;
        cur_next      = cur_reg;
        sp_next       = sp_reg;
        out_vld_next  = out_vld_reg;
        out_last_next = out_last_reg;
        out_sym_next  = out_sym_reg;
        out_len_next  = out_len_reg;
        out_code_next = out_code_reg;

        // Running pair of lightest live nodes; a later index never wins a tie.
        if (rd_vld_reg && live_reg[rd_idx_reg]) begin
            if (!b1v_reg || (wt_rd_data < b1w_reg)) begin
                b2_next  = b1_reg;
                b2w_next = b1w_reg;
                b2v_next = b1v_reg;
                b1_next  = rd_idx_reg;
                b1w_next = wt_rd_data;
                b1v_next = 1'b1;
            end else if (!b2v_reg || (wt_rd_data < b2w_reg)) begin
                b2_next  = rd_idx_reg;
                b2w_next = wt_rd_data;
                b2v_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (in_beat) begin
                    cnt_next = n_new;
                    if (s_tlast) begin
                        cnt_next  = '0;
                        n_next    = n_new;
                        next_next = NODE_W'(n_new);
                        for (int i = 0; i < NODE_DEPTH; i++) begin
                            live_next[i] = (i < int'(n_new));
                        end
                        scan_idx_next = '0;
                        b1v_next      = 1'b0;
                        b2v_next      = 1'b0;
                        sp_next       = '0;
                        cur_next      = '{node: '0, len: '0, code: '0};
                        state_next    = (n_new == CNT_W'(1)) ? ST_EVAL : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_vld_next = 1'b1;
                rd_idx_next = scan_idx_reg;
                if (scan_idx_reg == next_reg - NODE_W'(1)) begin
                    state_next = ST_SCAN_TAIL;
                end else begin
                    scan_idx_next = scan_idx_reg + NODE_W'(1);
                end
            end
            ST_SCAN_TAIL: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                live_next[b1_reg]   = 1'b0;
                live_next[b2_reg]   = 1'b0;
                live_next[next_reg] = 1'b1;
                if ((CNT_W+1)'(next_reg) == root_idx) begin
                    cur_next   = '{node: next_reg, len: '0, code: '0};
                    state_next = ST_EVAL;
                end else begin
                    next_next     = next_reg + NODE_W'(1);
                    scan_idx_next = '0;
                    b1v_next      = 1'b0;
                    b2v_next      = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_EVAL: begin
                state_next = ((CNT_W+1)'(cur_reg.node) < (CNT_W+1)'(n_reg)) ? ST_LEAF
                                                                           : ST_CHILD;
            end
            ST_CHILD: begin
                sp_next    = sp_reg + CNT_W'(1);
                cur_next   = '{node: ch_rd_data.left, len: cur_reg.len + LEN_W'(1),
                               code: {cur_reg.code[CODE_W-2:0], 1'b0}};
                state_next = ST_EVAL;
            end
            ST_LEAF: begin
                out_vld_next  = 1'b1;
                out_last_next = (sp_reg == '0);
                out_sym_next  = sym_rd_data;
                out_len_next  = cur_reg.len;
                out_code_next = cur_reg.code;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    out_vld_next = 1'b0;
                    if (sp_reg == '0) begin
                        state_next = ST_LOAD;
                    end else begin
                        sp_next    = sp_reg - CNT_W'(1);
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                cur_next   = stk_rd_data;
                state_next = ST_EVAL;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            n_reg       <= '0;
            next_reg    <= '0;
            live_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            b1v_reg     <= 1'b0;
            b2v_reg     <= 1'b0;
            sp_reg      <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            next_reg    <= next_next;
            live_reg    <= live_next;
            rd_vld_reg  <= rd_vld_next;
            b1v_reg     <= b1v_next;
            b2v_reg     <= b2v_next;
            sp_reg      <= sp_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= rd_idx_next;
        b1_reg       <= b1_next;
        b1w_reg      <= b1w_next;
        b2_reg       <= b2_next;
        b2w_reg      <= b2w_next;
        cur_reg      <= cur_next;
        out_last_reg <= out_last_next;
        out_sym_reg  <= out_sym_next;
        out_len_reg  <= out_len_next;
        out_code_reg <= out_code_next;
    end

endmodule

>>> hw/rtl/hcb_checker.sv
// Port checker of the code builder and its binding to the top level.
`include "huffman_code_builder_top_macros.svh"

module hcb_checker
    import hcb_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    `HCB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "code beat dropped while stalled")
    `HCB_ASSERT_SAME(a_no_load_while_out, aclk, aresetn, m_tvalid, !s_tready, "input taken while codes pending")
    `HCB_ASSERT_NEXT(a_build_stalls_in, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready, "input not stalled after final beat")
    `HCB_ASSERT_SAME(a_empty_code, aclk, aresetn, m_tvalid && (m_tdata[13:8] == 6'd0), m_tdata[76:14] == '0, "bits set in a zero-length code")

endmodule

bind huffman_code_builder_top hcb_checker u_hcb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
